FILE: src/fpp_pkg.sv
package fpp_pkg;

  localparam int MOD_STEPS    = 32;
  localparam int DIV_STEPS    = 17;
  localparam int HORNER_STEPS = 6;
  // stage A, stage B, remainder, fold, quotient, square, horner, clamp, powers
  localparam int SHP_LAT = 2 + MOD_STEPS + 1 + DIV_STEPS + 2 + 2 * HORNER_STEPS + 1 + 11;

  localparam int SHAPE_W = 17;
  localparam logic [SHAPE_W-1:0] SHAPE_ONE = 17'd65536;

  localparam logic signed [32:0] Q30_ONE = 33'sd1073741824;

  localparam logic signed [32:0] COS_COEF [HORNER_STEPS+1] = '{
    33'sd1073741824, 33'sd1324675879, 33'sd272375560, 33'sd22401994,
    33'sd987048, 33'sd27061, 33'sd506
  };

  localparam logic [30:0]        RST_TIME_STEP  = 31'd656;
  localparam logic signed [31:0] RST_CHARGE     = 32'sd0;
  localparam logic signed [31:0] RST_MAGNETIC   = 32'sd0;
  localparam logic signed [31:0] RST_ELECTRIC   = 32'sd0;
  localparam logic signed [31:0] RST_PLATE_LOW  = 32'sd0;
  localparam logic signed [31:0] RST_PLATE_HIGH = 32'sd65536;

  typedef enum logic [2:0] {
    CFG_TIME_STEP   = 3'd0,
    CFG_CHARGE_MASS = 3'd1,
    CFG_MAGNETIC    = 3'd2,
    CFG_ELECTRIC    = 3'd3,
    CFG_PLATE_LOW   = 3'd4,
    CFG_PLATE_HIGH  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] pair_accel_x;
    logic signed [31:0] pair_accel_y;
    logic signed [31:0] pair_accel_z;
  } particle_t;

  typedef struct packed {
    logic near_low;
    logic gap_zero;
  } shp_flag_t;

  // round to nearest, ties toward +inf
  function automatic logic signed [63:0] rnd64(input logic signed [63:0] p, input int n);
    rnd64 = (p + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      sat32 = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  function automatic logic [31:0] abs_diff(input logic signed [31:0] a,
                                           input logic signed [31:0] b);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    abs_diff = d[32] ? 32'(-d) : d[31:0];
  endfunction

endpackage

FILE: src/field_particle_push.sv
// throughput: one particle per cycle while no result beat is stalled, set by the
//   32-stage remainder and 17-stage quotient pipelines of the plate shape unit
// a stalled result beat holds the whole pipeline in place
// reset clears all valid bits and loads the register defaults
module field_particle_push import fpp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  input  logic signed [31:0] in_vel_z,
  input  logic signed [31:0] in_pair_accel_x,
  input  logic signed [31:0] in_pair_accel_y,
  input  logic signed [31:0] in_pair_accel_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_new_pos_x,
  output logic signed [31:0] out_new_pos_y,
  output logic signed [31:0] out_new_pos_z,
  output logic signed [31:0] out_new_vel_x,
  output logic signed [31:0] out_new_vel_y,
  output logic signed [31:0] out_new_vel_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  // config registers
  logic [30:0]        dt_r;
  logic signed [31:0] k_r, bfield_r, efield_r, zlo_r, zhi_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r     <= RST_TIME_STEP;
      k_r      <= RST_CHARGE;
      bfield_r <= RST_MAGNETIC;
      efield_r <= RST_ELECTRIC;
      zlo_r    <= RST_PLATE_LOW;
      zhi_r    <= RST_PLATE_HIGH;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_TIME_STEP:   dt_r     <= cfg_data[30:0];
        CFG_CHARGE_MASS: k_r      <= cfg_data;
        CFG_MAGNETIC:    bfield_r <= cfg_data;
        CFG_ELECTRIC:    efield_r <= cfg_data;
        CFG_PLATE_LOW:   zlo_r    <= cfg_data;
        CFG_PLATE_HIGH:  zhi_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // field coefficients, settle long before an item reaches them
  logic signed [63:0] kb_p_r, ke_p_r;
  logic signed [31:0] kb_r, ke_r;

  always_ff @(posedge clk) begin
    kb_p_r <= k_r * bfield_r;
    ke_p_r <= k_r * efield_r;
    kb_r   <= sat32(rnd64(kb_p_r, 16));
    ke_r   <= sat32(rnd64(ke_p_r, 16));
  end

  logic adv;
  logic out_valid_r;
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // input beat
  logic      v0_r;
  particle_t in_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_r <= '{pos_x: in_pos_x, pos_y: in_pos_y, pos_z: in_pos_z,
                vel_x: in_vel_x, vel_y: in_vel_y, vel_z: in_vel_z,
                pair_accel_x: in_pair_accel_x, pair_accel_y: in_pair_accel_y,
                pair_accel_z: in_pair_accel_z};
    end
  end

  // particle data waits for the shape unit
  particle_t          dly_r [SHP_LAT];
  logic [SHP_LAT-1:0] dly_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dly_v_r <= '0;
    end else if (adv) begin
      dly_v_r <= {dly_v_r[SHP_LAT-2:0], v0_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dly_r[0] <= in_r;
      for (int i = 1; i < SHP_LAT; i++) begin
        dly_r[i] <= dly_r[i-1];
      end
    end
  end

  logic [SHAPE_W-1:0] shape;
  logic               near_low;

  fpp_shape u_shape (
    .clk          (clk),
    .en           (adv),
    .pos_z        (in_r.pos_z),
    .plate_low_z  (zlo_r),
    .plate_high_z (zhi_r),
    .shape        (shape),
    .near_low     (near_low)
  );

  particle_t          pd;
  logic signed [31:0] dpos [3];
  logic signed [31:0] dvel [3];
  logic signed [31:0] dacc [3];
  logic signed [31:0] dts;

  assign pd      = dly_r[SHP_LAT-1];
  assign dpos[0] = pd.pos_x;
  assign dpos[1] = pd.pos_y;
  assign dpos[2] = pd.pos_z;
  assign dvel[0] = pd.vel_x;
  assign dvel[1] = pd.vel_y;
  assign dvel[2] = pd.vel_z;
  assign dacc[0] = pd.pair_accel_x;
  assign dacc[1] = pd.pair_accel_y;
  assign dacc[2] = pd.pair_accel_z;
  assign dts     = $signed({1'b0, dt_r});

  logic [5:0] stg_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      stg_v_r     <= {stg_v_r[4:0], dly_v_r[SHP_LAT-1]};
      out_valid_r <= stg_v_r[5];
    end
  end

  // field and kinematic stages
  logic signed [49:0] et_p_r;
  logic signed [63:0] mx_p_r, my_p_r;
  logic               near1_r;
  logic signed [31:0] pos1_r [3], vel1_r [3], acc1_r [3];

  logic signed [63:0] eterm;
  logic signed [48:0] ext2_r [3];
  logic signed [31:0] pos2_r [3], vel2_r [3], acc2_r [3];

  logic signed [31:0] a3_r [3], pos3_r [3], vel3_r [3];
  logic signed [62:0] adt4_r [3], vdt4_r [3];
  logic signed [31:0] pos4_r [3], vel4_r [3];
  logic signed [31:0] dv5_r [3], pos5_r [3], vel5_r [3];
  logic signed [47:0] pv5_r [3];
  logic signed [62:0] ddt6_r [3];
  logic signed [31:0] nv6_r [3], pos6_r [3];
  logic signed [47:0] pv6_r [3];
  logic signed [31:0] np_out_r [3], nv_out_r [3];

  assign eterm = rnd64(64'(et_p_r), 16);

  always_ff @(posedge clk) begin
    if (adv) begin
      et_p_r  <= ke_r * $signed({1'b0, shape});
      mx_p_r  <= kb_r * dvel[1];
      my_p_r  <= kb_r * dvel[0];
      near1_r <= near_low;
      pos1_r  <= dpos;
      vel1_r  <= dvel;
      acc1_r  <= dacc;

      ext2_r[0] <= 49'(-rnd64(mx_p_r, 16));
      ext2_r[1] <= 49'(rnd64(my_p_r, 16) - 64'(ke_r) + eterm);
      ext2_r[2] <= 49'((near1_r == (eterm < 0)) ? -eterm : eterm);
      pos2_r    <= pos1_r;
      vel2_r    <= vel1_r;
      acc2_r    <= acc1_r;

      for (int i = 0; i < 3; i++) begin
        a3_r[i]     <= sat32(64'(acc2_r[i]) + 64'(ext2_r[i]));
        adt4_r[i]   <= a3_r[i] * dts;
        vdt4_r[i]   <= vel3_r[i] * dts;
        dv5_r[i]    <= sat32(rnd64(64'(adt4_r[i]), 16));
        pv5_r[i]    <= 48'(rnd64(64'(vdt4_r[i]), 16));
        ddt6_r[i]   <= dv5_r[i] * dts;
        nv6_r[i]    <= sat32(64'(vel5_r[i]) + 64'(dv5_r[i]));
        np_out_r[i] <= sat32(64'(pos6_r[i]) + 64'(pv6_r[i]) + rnd64(64'(ddt6_r[i]), 17));
      end
      pos3_r   <= pos2_r;
      vel3_r   <= vel2_r;
      pos4_r   <= pos3_r;
      vel4_r   <= vel3_r;
      pos5_r   <= pos4_r;
      vel5_r   <= vel4_r;
      pos6_r   <= pos5_r;
      pv6_r    <= pv5_r;
      nv_out_r <= nv6_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_new_pos_x = np_out_r[0];
  assign out_new_pos_y = np_out_r[1];
  assign out_new_pos_z = np_out_r[2];
  assign out_new_vel_x = nv_out_r[0];
  assign out_new_vel_y = nv_out_r[1];
  assign out_new_vel_z = nv_out_r[2];

  a_shape_range: assert property (@(posedge clk) disable iff (!rst_n)
    dly_v_r[SHP_LAT-1] |-> shape <= SHAPE_ONE)
    else $error("shape above one");

  a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(stg_v_r[5]))
    else $error("result beat without a pipeline item");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(stg_v_r) && $stable(dly_v_r) && $stable(v0_r))
    else $error("pipeline moved during stall");

endmodule

FILE: src/fpp_shape.sv
module fpp_shape import fpp_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [31:0]       pos_z,
  input  logic signed [31:0]       plate_low_z,
  input  logic signed [31:0]       plate_high_z,
  output logic [SHAPE_W-1:0]       shape,
  output logic                     near_low
);

  function automatic logic [30:0] q30_rnd(input logic [60:0] p);
    q30_rnd = 31'((p + 61'd536870912) >> 30);
  endfunction

  // distances
  logic [31:0] dl_a_r, dh_a_r, gap_a_r;
  logic [31:0] d_b_r, gap_b_r;
  shp_flag_t   flag_r [SHP_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      dl_a_r    <= abs_diff(pos_z, plate_low_z);
      dh_a_r    <= abs_diff(pos_z, plate_high_z);
      gap_a_r   <= abs_diff(plate_high_z, plate_low_z);
      d_b_r     <= (dl_a_r <= dh_a_r) ? dl_a_r : dh_a_r;
      gap_b_r   <= gap_a_r;
      flag_r[0] <= '{near_low: (dl_a_r <= dh_a_r), gap_zero: (gap_a_r == 32'd0)};
      for (int i = 1; i < SHP_LAT - 1; i++) begin
        flag_r[i] <= flag_r[i-1];
      end
    end
  end

  // d mod gap, one bit a stage
  logic [31:0] mrem_r [MOD_STEPS];
  logic [31:0] md_r   [MOD_STEPS];
  logic [31:0] mgap_r [MOD_STEPS];

  for (genvar j = 0; j < MOD_STEPS; j++) begin : g_mod
    logic [31:0] rem_in, d_in, gap_in;
    logic [32:0] t;
    assign rem_in = (j == 0) ? 32'd0   : mrem_r[(j == 0) ? 0 : j - 1];
    assign d_in   = (j == 0) ? d_b_r   : md_r[(j == 0) ? 0 : j - 1];
    assign gap_in = (j == 0) ? gap_b_r : mgap_r[(j == 0) ? 0 : j - 1];
    assign t = {rem_in, d_in[MOD_STEPS-1-j]};
    always_ff @(posedge clk) begin
      if (en) begin
        mrem_r[j] <= (t >= {1'b0, gap_in}) ? 32'(t - {1'b0, gap_in}) : t[31:0];
        md_r[j]   <= d_in;
        mgap_r[j] <= gap_in;
      end
    end
  end

  // fold to the nearer half period and scale
  logic [31:0] m_rem, g_rem, f_val;
  logic [48:0] num_r;
  logic [31:0] gap_f_r;

  assign m_rem = mrem_r[MOD_STEPS-1];
  assign g_rem = mgap_r[MOD_STEPS-1] - m_rem;
  assign f_val = (g_rem < m_rem) ? g_rem : m_rem;

  always_ff @(posedge clk) begin
    if (en) begin
      num_r   <= (49'(f_val) << 17) + 49'(mgap_r[MOD_STEPS-1] >> 1);
      gap_f_r <= mgap_r[MOD_STEPS-1];
    end
  end

  // quotient, one bit a stage
  logic [48:0]         drem_r [DIV_STEPS];
  logic [DIV_STEPS-1:0] dq_r  [DIV_STEPS];
  logic [31:0]         dgap_r [DIV_STEPS];

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    logic [48:0]          rem_in, cmp;
    logic [DIV_STEPS-1:0] q_in;
    logic [31:0]          gap_in;
    logic                 take;
    assign rem_in = (i == 0) ? num_r   : drem_r[(i == 0) ? 0 : i - 1];
    assign q_in   = (i == 0) ? '0      : dq_r[(i == 0) ? 0 : i - 1];
    assign gap_in = (i == 0) ? gap_f_r : dgap_r[(i == 0) ? 0 : i - 1];
    assign cmp    = 49'(gap_in) << (DIV_STEPS - 1 - i);
    assign take   = (rem_in >= cmp);
    always_ff @(posedge clk) begin
      if (en) begin
        drem_r[i] <= take ? rem_in - cmp : rem_in;
        dq_r[i]   <= {q_in[DIV_STEPS-2:0], take};
        dgap_r[i] <= gap_in;
      end
    end
  end

  // w = u^2 in Q30
  logic [32:0] uu_r;
  logic [30:0] w_r;

  always_ff @(posedge clk) begin
    if (en) begin
      uu_r <= 33'(dq_r[DIV_STEPS-1]) * 33'(dq_r[DIV_STEPS-1]);
      w_r  <= 31'((uu_r + 33'd2) >> 2);
    end
  end

  // cosine polynomial, multiply then subtract
  logic signed [63:0] hp_r   [HORNER_STEPS];
  logic signed [32:0] hacc_r [HORNER_STEPS];
  logic [30:0]        hwm_r  [HORNER_STEPS];
  logic [30:0]        hws_r  [HORNER_STEPS];

  for (genvar h = 0; h < HORNER_STEPS; h++) begin : g_horner
    logic signed [32:0] acc_in;
    logic [30:0]        w_in;
    assign acc_in = (h == 0) ? COS_COEF[HORNER_STEPS] : hacc_r[(h == 0) ? 0 : h - 1];
    assign w_in   = (h == 0) ? w_r : hws_r[(h == 0) ? 0 : h - 1];
    always_ff @(posedge clk) begin
      if (en) begin
        hp_r[h]   <= acc_in * $signed({1'b0, w_in});
        hwm_r[h]  <= w_in;
        hacc_r[h] <= COS_COEF[HORNER_STEPS-1-h] - 33'(rnd64(hp_r[h], 30));
        hws_r[h]  <= hwm_r[h];
      end
    end
  end

  // clamp and 15th power
  logic signed [32:0] hacc_last;
  logic [30:0] c_r, cc_a_r, cc_b_r, c2_r, c3_r, c3_a_r, c3_b_r, c3_c_r, c3_d_r;
  logic [30:0] c6_r, c12_r, c15_r;
  logic [60:0] pp_c2_r, pp_c3_r, pp_c6_r, pp_c12_r, pp_c15_r;
  logic [SHAPE_W-1:0] s_r;

  assign hacc_last = hacc_r[HORNER_STEPS-1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (hacc_last < 0) begin
        c_r <= 31'd0;
      end else if (hacc_last > Q30_ONE) begin
        c_r <= Q30_ONE[30:0];
      end else begin
        c_r <= hacc_last[30:0];
      end
      pp_c2_r  <= 61'(c_r) * 61'(c_r);
      cc_a_r   <= c_r;
      c2_r     <= q30_rnd(pp_c2_r);
      cc_b_r   <= cc_a_r;
      pp_c3_r  <= 61'(c2_r) * 61'(cc_b_r);
      c3_r     <= q30_rnd(pp_c3_r);
      pp_c6_r  <= 61'(c3_r) * 61'(c3_r);
      c3_a_r   <= c3_r;
      c6_r     <= q30_rnd(pp_c6_r);
      c3_b_r   <= c3_a_r;
      pp_c12_r <= 61'(c6_r) * 61'(c6_r);
      c3_c_r   <= c3_b_r;
      c12_r    <= q30_rnd(pp_c12_r);
      c3_d_r   <= c3_c_r;
      pp_c15_r <= 61'(c12_r) * 61'(c3_d_r);
      c15_r    <= q30_rnd(pp_c15_r);
      s_r      <= flag_r[SHP_LAT-3].gap_zero ? '0 :
                  SHAPE_W'((c15_r + 31'd8192) >> 14);
    end
  end

  assign shape    = s_r;
  assign near_low = flag_r[SHP_LAT-2].near_low;

endmodule
